/* hdl/bkxc_pkg.sv */
// Shared constants and types for the block key XOR checksum cipher.
`timescale 1ns / 1ps
`default_nettype none

package bkxc_pkg;

    localparam int BLOCK_KEYS_DEF = 11;
    localparam int KEY_BASE_N     = 11;
    localparam int RES_MAX        = 5;
    localparam int SIG_LEN        = 4;

    localparam logic [15:0] KEY_MASK = 16'h38AA;
    localparam logic [31:0] SIG_WORD = 32'h5c331a55;

    localparam logic [15:0] KEY_BASE [KEY_BASE_N] = '{
        16'ha820, 16'h71f0, 16'h88da, 16'h1fff, 16'h2718, 16'he6a1,
        16'h42b8, 16'h0ce9, 16'h10ec, 16'hd77d, 16'h3fa9
    };

    // register byte addresses
    localparam logic [2:0] ADDR_DIRECTION = 3'd0;

    // direction register codes
    localparam logic DIR_ENCRYPT = 1'b0;
    localparam logic DIR_DECRYPT = 1'b1;

    localparam logic [2:0] HDR_DONE = 3'd4;

    // output bytes caused by one input byte
    typedef struct packed {
        logic [RES_MAX-1:0][7:0] data;
        logic [RES_MAX-1:0]      raw;
        logic [2:0]              count;
        logic                    last;
    } bkxc_res_t;

endpackage

`default_nettype wire

/* hdl/bkxc_engine.sv */
// Per-byte cipher, checksum and signature handling with the stream state.
`timescale 1ns / 1ps
`default_nettype none

module bkxc_engine
    import bkxc_pkg::*;
#(
    parameter int BLOCK_KEYS = BLOCK_KEYS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       advance,
    input  wire logic [7:0] item_byte,
    input  wire logic       item_last,
    input  wire logic       decrypt,
    output bkxc_res_t       res
);

    localparam int P_W      = $clog2(2 * BLOCK_KEYS);
    localparam int KI_W     = (BLOCK_KEYS > 1) ? $clog2(BLOCK_KEYS) : 1;
    localparam int SH_W     = 16 + $clog2(2 * BLOCK_KEYS + 1);
    localparam int SH_BYTES = (SH_W + 7) / 8;
    localparam logic [P_W-1:0] LAST_POS = P_W'(2 * BLOCK_KEYS - 1);

    logic [15:0] key_tab [BLOCK_KEYS];

    genvar g;
    generate
        for (g = 0; g < BLOCK_KEYS; g++)
        begin : g_key
            assign key_tab[g] = KEY_BASE[g % KEY_BASE_N] ^ KEY_MASK;
        end
    endgenerate

    logic [P_W-1:0]  pos_reg, pos_next;
    logic [15:0]     rc_reg, rc_next;
    logic [16:0]     sl_reg, sl_next;
    logic [SH_W-1:0] sh_reg, sh_next;
    logic [2:0]      hc_reg, hc_next;
    logic [23:0]     hold_reg, hold_next;
    logic            bypass_reg, bypass_next;

    logic [KI_W-1:0]       key_idx;
    logic [15:0]           key_word;
    logic [7:0]            key_byte;
    logic [7:0]            cipher_out;
    logic [7:0]            check_byte;
    logic [16:0]           sl_add;
    logic [16:0]           sl_upd;
    logic [SH_W-1:0]       sh_upd;
    logic [SH_BYTES*8-1:0] sh_ext;
    logic [11:0]           fold_sum;
    logic [8:0]            fold2;
    logic [7:0]            sh_mod;
    logic [15:0]           rc_upd;
    logic                  blk_end;
    logic                  cipher_en;
    logic [31:0]           hold_ext;
    logic [31:0]           hdr_word;

    // cipher datapath for the current byte
    always_comb
    begin
        key_idx    = KI_W'(pos_reg >> 1);
        key_word   = key_tab[key_idx] ^ rc_reg;
        key_byte   = pos_reg[0] ? key_word[15:8] : key_word[7:0];
        // unpaired final byte of a short block passes through
        if (item_last && !pos_reg[0])
        begin
            key_byte = 8'h00;
        end
        cipher_out = item_byte ^ key_byte;
        check_byte = (decrypt == DIR_DECRYPT) ? item_byte : cipher_out;

        sl_add = sl_reg + 17'(check_byte);
        sl_upd = (sl_add >= 17'd255) ? sl_add - 17'd255 : sl_add;
        sh_upd = sh_reg + SH_W'(sl_upd);

        // mod 255 by folding bytes
        sh_ext   = (SH_BYTES*8)'(sh_upd);
        fold_sum = '0;
        for (int i = 0; i < SH_BYTES; i++)
        begin
            fold_sum = fold_sum + 12'(sh_ext[8*i +: 8]);
        end
        fold2  = 9'(fold_sum[7:0]) + 9'(fold_sum[11:8]);
        sh_mod = (fold2 >= 9'd255) ? 8'(fold2 - 9'd255) : fold2[7:0];
        rc_upd = {sl_upd[7:0], 8'h00} + {8'h00, sh_mod};

        blk_end = (pos_reg == LAST_POS);
    end

    // signature handling and result assembly
    always_comb
    begin
        pos_next    = pos_reg;
        rc_next     = rc_reg;
        sl_next     = sl_reg;
        sh_next     = sh_reg;
        hc_next     = hc_reg;
        hold_next   = hold_reg;
        bypass_next = bypass_reg;
        cipher_en   = 1'b0;
        res         = '0;
        res.last    = item_last;
        hold_ext    = {8'h00, hold_reg};
        hdr_word    = hold_ext | {item_byte, 24'h000000};

        if (decrypt == DIR_ENCRYPT)
        begin
            cipher_en = 1'b1;
            if (hc_reg != HDR_DONE)
            begin
                for (int i = 0; i < SIG_LEN; i++)
                begin
                    res.data[i] = SIG_WORD[8*i +: 8];
                end
                res.data[SIG_LEN] = cipher_out;
                res.count         = 3'(RES_MAX);
                hc_next           = HDR_DONE;
                hold_next         = '0;
            end
            else
            begin
                res.data[0] = cipher_out;
                res.count   = 3'd1;
            end
        end
        else if (bypass_reg)
        begin
            res.data[0] = item_byte;
            res.raw[0]  = 1'b1;
            res.count   = 3'd1;
        end
        else if (hc_reg != HDR_DONE)
        begin
            if (hc_reg == 3'd3 && hdr_word == SIG_WORD)
            begin
                hc_next = HDR_DONE;
            end
            else if (hc_reg == 3'd3 || item_last)
            begin
                // mismatch or short stream: held bytes then this one, raw
                for (int i = 0; i < SIG_LEN; i++)
                begin
                    res.data[i] = (3'(i) == hc_reg) ? item_byte : hold_ext[8*i +: 8];
                    res.raw[i]  = (3'(i) <= hc_reg);
                end
                res.count = hc_reg + 3'd1;
                if (hc_reg == 3'd3)
                begin
                    bypass_next = 1'b1;
                end
            end
            else
            begin
                hold_next = hold_reg | (24'(item_byte) << (8 * hc_reg));
                hc_next   = hc_reg + 3'd1;
            end
        end
        else
        begin
            cipher_en   = 1'b1;
            res.data[0] = cipher_out;
            res.count   = 3'd1;
        end

        if (cipher_en)
        begin
            if (blk_end)
            begin
                pos_next = '0;
                rc_next  = rc_upd;
                sl_next  = 17'(rc_upd);
                sh_next  = SH_W'(rc_upd);
            end
            else
            begin
                pos_next = pos_reg + P_W'(1);
                sl_next  = sl_upd;
                sh_next  = sh_upd;
            end
        end

        if (item_last)
        begin
            pos_next    = '0;
            rc_next     = 16'hffff;
            sl_next     = 17'h0ffff;
            sh_next     = SH_W'(16'hffff);
            hc_next     = '0;
            hold_next   = '0;
            bypass_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            rc_reg     <= 16'hffff;
            sl_reg     <= 17'h0ffff;
            sh_reg     <= SH_W'(16'hffff);
            hc_reg     <= '0;
            hold_reg   <= '0;
            bypass_reg <= 1'b0;
        end
        else if (advance)
        begin
            pos_reg    <= pos_next;
            rc_reg     <= rc_next;
            sl_reg     <= sl_next;
            sh_reg     <= sh_next;
            hc_reg     <= hc_next;
            hold_reg   <= hold_next;
            bypass_reg <= bypass_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/block_key_xor_checksum_cipher_core.sv */
// Top level: stream ports, input skid stage, result burst register, config port.
//
//  channel | direction | transaction contents
//  s_*     | in        | tdata[7:0] data_byte, tlast last_byte
//  m_*     | out       | tdata[7:0] out_byte, tlast run_last,
//          |           | tuser[0] stream_last, tuser[1] raw_pass
//  APB     | in/out    | 0x0 direction (bit 0: 0 encrypt, 1 decrypt)
//
// One input byte per cycle when each causes one output byte and m_tready is
// high; an item with n output bytes holds the output port for all n (up to 5
// for the first encrypted byte, which carries the signature). A byte passes
// the main input stage, then the result burst register. Reset clears all
// stream state; a byte flagged last also returns the stream state to reset.
// s_tready is registered: a two-entry input buffer absorbs output stalls.
`timescale 1ns / 1ps
`default_nettype none

module block_key_xor_checksum_cipher_core
    import bkxc_pkg::*;
#(
    parameter int BLOCK_KEYS = BLOCK_KEYS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // slave stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,
    // master stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic             m_tlast,
    output logic [1:0]       m_tuser,   // [0] stream_last, [1] raw_pass
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic       direction_reg;

    logic       main_valid_reg;
    logic [7:0] main_byte_reg;
    logic       main_last_reg;
    logic       skid_valid_reg;
    logic [7:0] skid_byte_reg;
    logic       skid_last_reg;

    logic       burst_valid_reg;
    logic [2:0] burst_idx_reg;
    bkxc_res_t  burst_res_reg;

    bkxc_res_t  eng_res;
    logic       s_fire;
    logic       m_fire;
    logic       burst_end;
    logic       burst_free;
    logic       move;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_DIRECTION);
    assign prdata = (paddr == ADDR_DIRECTION) ? {31'h0, direction_reg} : 32'h0;

    assign s_tready   = !skid_valid_reg;
    assign s_fire     = s_tvalid && s_tready;
    assign m_fire     = m_tvalid && m_tready;
    assign burst_end  = (burst_idx_reg == burst_res_reg.count - 3'd1);
    assign burst_free = !burst_valid_reg || (m_fire && burst_end);
    assign move       = main_valid_reg && burst_free;

    assign m_tvalid   = burst_valid_reg;
    assign m_tdata    = burst_res_reg.data[burst_idx_reg];
    assign m_tlast    = burst_end;
    assign m_tuser[0] = burst_end && burst_res_reg.last;
    assign m_tuser[1] = burst_res_reg.raw[burst_idx_reg];

    bkxc_engine #(
        .BLOCK_KEYS (BLOCK_KEYS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (move),
        .item_byte (main_byte_reg),
        .item_last (main_last_reg),
        .decrypt   (direction_reg),
        .res       (eng_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= DIR_ENCRYPT;
        end
        else if (cfg_wr)
        begin
            direction_reg <= pwdata[0];
        end
    end

    // input buffer: main stage feeds the engine, skid catches one transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!main_valid_reg || move)
        begin
            if (skid_valid_reg)
            begin
                main_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= s_fire;
            end
        end
        else if (s_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_valid_reg || move)
        begin
            main_byte_reg <= skid_valid_reg ? skid_byte_reg : s_tdata;
            main_last_reg <= skid_valid_reg ? skid_last_reg : s_tlast;
        end
        if (s_fire)
        begin
            skid_byte_reg <= s_tdata;
            skid_last_reg <= s_tlast;
        end
    end

    // result burst: bytes of one item go out one per cycle while m_tready is high
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_valid_reg <= 1'b0;
            burst_idx_reg   <= '0;
        end
        else if (move)
        begin
            burst_valid_reg <= (eng_res.count != 3'd0);
            burst_idx_reg   <= '0;
        end
        else if (m_fire)
        begin
            if (burst_end)
            begin
                burst_valid_reg <= 1'b0;
            end
            else
            begin
                burst_idx_reg <= burst_idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            burst_res_reg <= eng_res;
        end
    end

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        burst_valid_reg |-> (burst_idx_reg < burst_res_reg.count))
        else $error("burst index past result count");

    a_skid_needs_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid stage holds data while main stage is empty");

    a_burst_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (burst_valid_reg && !m_tready) |=> (burst_valid_reg && $stable(burst_idx_reg)))
        else $error("result burst moved while output stalled");

endmodule

`default_nettype wire
